// File: src/ypcb_pkg.sv
// ypcb_pkg: constants, table types and helpers for the yaw/pitch camera basis
// holds the quarter-wave sine table built at elaboration and the field helpers
// used by yaw_pitch_camera_basis; no dependencies
package ypcb_pkg;

  localparam int ANGLE_STEPS_PER_DEGREE = 16;
  localparam int VECTOR_FRAC_BITS = 14;

  localparam int QUARTER_STEPS = 90 * ANGLE_STEPS_PER_DEGREE;
  localparam int TURN_STEPS = 360 * ANGLE_STEPS_PER_DEGREE;
  localparam int PITCH_LIMIT = 89 * ANGLE_STEPS_PER_DEGREE;

  localparam int DELTA_W = 14;
  localparam int FIELD_W = 16;
  localparam int YAW_W = $clog2(TURN_STEPS);
  localparam int PITCH_W = $clog2(PITCH_LIMIT + 1) + 1;
  localparam int ADDR_W = $clog2(QUARTER_STEPS + 1);
  localparam int SIN_W = VECTOR_FRAC_BITS + 1;
  localparam int SIN_DEPTH = QUARTER_STEPS + 1;
  localparam int VAL_W = SIN_W + FIELD_W;

  localparam int SIN_SHIFT = 30 - VECTOR_FRAC_BITS;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] HALF_TURN_STEPS = 64'(180 * ANGLE_STEPS_PER_DEGREE);
  localparam logic [63:0] HALF_TURN_ROUND = 64'(180 * ANGLE_STEPS_PER_DEGREE / 2);

  typedef logic [63:0] denom_list_t [7];
  localparam denom_list_t SIN_DENOMS = '{64'd210, 64'd156, 64'd110, 64'd72,
                                         64'd42, 64'd20, 64'd6};

  typedef logic [SIN_W-1:0] sin_table_t [SIN_DEPTH];

  // sine of a in [0, quarter turn] steps, magnitude in vector format
  function automatic logic [SIN_W-1:0] sin_entry(input int a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x = (64'(a) * PI_Q30 + HALF_TURN_ROUND) / HALF_TURN_STEPS;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int i = 0; i < 7; i++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / SIN_DENOMS[i];
    end
    s = (x * t) >> 30;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    if (SIN_SHIFT > 0) begin
      s = (s + (64'd1 << (SIN_SHIFT - 1))) >> SIN_SHIFT;
    end
    return s[SIN_W-1:0];
  endfunction

  function automatic sin_table_t build_sin_table();
    sin_table_t tbl;
    for (int a = 0; a < SIN_DEPTH; a++) begin
      tbl[a] = sin_entry(a);
    end
    return tbl;
  endfunction

  localparam sin_table_t SIN_TABLE = build_sin_table();

  // rounded product of two magnitudes in vector format
  function automatic logic [SIN_W-1:0] mag_mul(input logic [SIN_W-1:0] a,
                                               input logic [SIN_W-1:0] b);
    logic [2*SIN_W-1:0] p;
    p = a * b;
    p = p + ((2*SIN_W)'(1) << (VECTOR_FRAC_BITS - 1));
    p = p >> VECTOR_FRAC_BITS;
    return p[SIN_W-1:0];
  endfunction

  // sign a magnitude and keep the low field bits
  function automatic logic [FIELD_W-1:0] to_field(input logic [SIN_W-1:0] mag,
                                                  input logic neg);
    logic signed [VAL_W-1:0] v;
    v = $signed(VAL_W'(mag));
    if (neg) begin
      v = -v;
    end
    return v[FIELD_W-1:0];
  endfunction

endpackage

// File: src/yaw_pitch_camera_basis.sv
// yaw_pitch_camera_basis: accumulates yaw and pitch and emits forward, right, up
// depends on ypcb_pkg and two ypcb_ram instances holding the quarter-wave sine
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid, in_stall | yaw_delta, pitch_delta
//   out     | out_valid,out_stall| forward_x/y/z, right_x/y/z, up_x/y/z
//
// one transaction per cycle while in_stall is low; an accepted one sets s1_valid, then out_valid
// the two stages are the sine ram read and the product/sign stage
// after reset the sine rams are loaded, one entry per address, with in_stall high
// each stage holds while the one after it is full and stalled
module yaw_pitch_camera_basis (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ypcb_pkg::DELTA_W-1:0]    yaw_delta,
  input  logic signed [ypcb_pkg::DELTA_W-1:0]    pitch_delta,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    forward_x,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    forward_y,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    forward_z,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    right_x,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    right_y,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    right_z,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    up_x,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    up_y,
  output logic signed [ypcb_pkg::FIELD_W-1:0]    up_z
);

  localparam int YSUM_W = ypcb_pkg::YAW_W + 3;
  localparam int PSUM_W = ypcb_pkg::DELTA_W + 1;
  localparam int AW = ypcb_pkg::ADDR_W;
  localparam int YW = ypcb_pkg::YAW_W;
  localparam int PW = ypcb_pkg::PITCH_W;
  localparam int SW = ypcb_pkg::SIN_W;

  localparam logic signed [YSUM_W-1:0] TURN = YSUM_W'(ypcb_pkg::TURN_STEPS);
  localparam logic signed [PSUM_W-1:0] PLIM = PSUM_W'(ypcb_pkg::PITCH_LIMIT);
  localparam logic [YW:0] Q1 = (YW+1)'(ypcb_pkg::QUARTER_STEPS);
  localparam logic [YW:0] Q2 = (YW+1)'(2 * ypcb_pkg::QUARTER_STEPS);
  localparam logic [YW:0] Q3 = (YW+1)'(3 * ypcb_pkg::QUARTER_STEPS);
  localparam logic [YW:0] Q4 = (YW+1)'(4 * ypcb_pkg::QUARTER_STEPS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ypcb_pkg::QUARTER_STEPS);

  logic [YW-1:0]        yaw_angle;
  logic signed [PW-1:0] pitch_angle;
  logic [YW-1:0]        yaw_next;
  logic signed [PW-1:0] pitch_next;

  logic          filling;
  logic [AW-1:0] fill_addr;

  logic s1_valid;
  logic sy_neg;
  logic cy_neg;
  logic sp_neg;
  logic sy_neg_next;
  logic cy_neg_next;
  logic sp_neg_next;

  logic [AW-1:0] sy_addr;
  logic [AW-1:0] cy_addr;
  logic [AW-1:0] sp_addr;
  logic [AW-1:0] cp_addr;
  logic [SW-1:0] sy_mag;
  logic [SW-1:0] cy_mag;
  logic [SW-1:0] sp_mag;
  logic [SW-1:0] cp_mag;

  logic out_load;
  logic s1_load;
  logic accept;

  logic signed [YSUM_W-1:0] yaw_sum;
  logic signed [YSUM_W-1:0] yaw_wrap;
  logic signed [PSUM_W-1:0] pitch_sum;
  logic signed [PSUM_W-1:0] pitch_clamp;
  logic [YW:0]              y;
  logic [YW:0]              yaddr_s;
  logic [YW:0]              yaddr_c;
  logic signed [PW-1:0]     pitch_abs;

  assign out_load = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || out_load;
  assign in_stall = filling || !s1_load;
  assign accept   = in_valid && !in_stall;

  // angle update
  always_comb begin
    yaw_sum = $signed(YSUM_W'(yaw_angle)) + YSUM_W'(yaw_delta);
    priority if (yaw_sum >= TURN + TURN) begin
      yaw_wrap = yaw_sum - TURN - TURN;
    end else if (yaw_sum >= TURN) begin
      yaw_wrap = yaw_sum - TURN;
    end else if (yaw_sum < -TURN) begin
      yaw_wrap = yaw_sum + TURN + TURN;
    end else if (yaw_sum < 0) begin
      yaw_wrap = yaw_sum + TURN;
    end else begin
      yaw_wrap = yaw_sum;
    end
    yaw_next = yaw_wrap[YW-1:0];

    pitch_sum = PSUM_W'(pitch_angle) + PSUM_W'(pitch_delta);
    priority if (pitch_sum > PLIM) begin
      pitch_clamp = PLIM;
    end else if (pitch_sum < -PLIM) begin
      pitch_clamp = -PLIM;
    end else begin
      pitch_clamp = pitch_sum;
    end
    pitch_next = pitch_clamp[PW-1:0];
  end

  // quadrant folding into table addresses
  always_comb begin
    y = (YW+1)'(yaw_next);
    priority if (y < Q1) begin
      yaddr_s = y;
      yaddr_c = Q1 - y;
      sy_neg_next = 1'b0;
      cy_neg_next = 1'b0;
    end else if (y < Q2) begin
      yaddr_s = Q2 - y;
      yaddr_c = y - Q1;
      sy_neg_next = 1'b0;
      cy_neg_next = 1'b1;
    end else if (y < Q3) begin
      yaddr_s = y - Q2;
      yaddr_c = Q3 - y;
      sy_neg_next = 1'b1;
      cy_neg_next = 1'b1;
    end else begin
      yaddr_s = Q4 - y;
      yaddr_c = y - Q3;
      sy_neg_next = 1'b1;
      cy_neg_next = 1'b0;
    end
    sy_addr = yaddr_s[AW-1:0];
    cy_addr = yaddr_c[AW-1:0];

    sp_neg_next = pitch_next < 0;
    pitch_abs = sp_neg_next ? -pitch_next : pitch_next;
    sp_addr = pitch_abs[AW-1:0];
    cp_addr = LAST_ADDR - pitch_abs[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filling <= 1'b1;
      fill_addr <= '0;
    end else if (filling) begin
      if (fill_addr == LAST_ADDR) begin
        filling <= 1'b0;
      end else begin
        fill_addr <= fill_addr + AW'(1);
      end
    end
  end

  ypcb_ram #(
    .WIDTH (SW),
    .DEPTH (ypcb_pkg::SIN_DEPTH)
  ) u_yaw_ram (
    .clk     (clk),
    .we      (filling),
    .waddr   (fill_addr),
    .wdata   (ypcb_pkg::SIN_TABLE[fill_addr]),
    .re      (s1_load),
    .raddr_a (sy_addr),
    .raddr_b (cy_addr),
    .rdata_a (sy_mag),
    .rdata_b (cy_mag)
  );

  ypcb_ram #(
    .WIDTH (SW),
    .DEPTH (ypcb_pkg::SIN_DEPTH)
  ) u_pitch_ram (
    .clk     (clk),
    .we      (filling),
    .waddr   (fill_addr),
    .wdata   (ypcb_pkg::SIN_TABLE[fill_addr]),
    .re      (s1_load),
    .raddr_a (sp_addr),
    .raddr_b (cp_addr),
    .rdata_a (sp_mag),
    .rdata_b (cp_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle <= '0;
      pitch_angle <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        yaw_angle <= yaw_next;
        pitch_angle <= pitch_next;
      end
      if (s1_load) begin
        s1_valid <= accept;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      sy_neg <= sy_neg_next;
      cy_neg <= cy_neg_next;
      sp_neg <= sp_neg_next;
    end
    if (out_load) begin
      forward_x <= ypcb_pkg::to_field(ypcb_pkg::mag_mul(cy_mag, cp_mag), cy_neg);
      forward_y <= ypcb_pkg::to_field(sp_mag, sp_neg);
      forward_z <= ypcb_pkg::to_field(ypcb_pkg::mag_mul(sy_mag, cp_mag), sy_neg);
      right_x   <= ypcb_pkg::to_field(sy_mag, !sy_neg);
      right_z   <= ypcb_pkg::to_field(cy_mag, cy_neg);
      up_x      <= ypcb_pkg::to_field(ypcb_pkg::mag_mul(cy_mag, sp_mag),
                                      !(cy_neg ^ sp_neg));
      up_y      <= ypcb_pkg::to_field(cp_mag, 1'b0);
      up_z      <= ypcb_pkg::to_field(ypcb_pkg::mag_mul(sy_mag, sp_mag),
                                      !(sy_neg ^ sp_neg));
    end
  end

  assign right_y = '0;

endmodule

// File: src/ypcb_ram.sv
// ypcb_ram: generic single write port, dual read port ram with registered reads
// standalone, no package dependencies
module ypcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: src/ypcb_checker.sv
// ypcb_checker: port-level assertions for yaw_pitch_camera_basis
// bound to the top level below; uses ypcb_pkg for field widths
module ypcb_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [ypcb_pkg::FIELD_W-1:0] forward_x,
  input logic signed [ypcb_pkg::FIELD_W-1:0] right_y,
  input logic signed [ypcb_pkg::FIELD_W-1:0] up_y,
  input logic signed [ypcb_pkg::FIELD_W-1:0] up_z
);

  // sine load runs right after reset
  a_fill_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall && !out_valid)
    else $error("input open or result shown right after reset");

  a_right_y_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> right_y == '0)
    else $error("right_y not zero");

  // pitch is within 89 degrees so its cosine is never negative
  a_up_y_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !up_y[ypcb_pkg::FIELD_W-1])
    else $error("up_y negative");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(forward_x) && $stable(up_z))
    else $error("stalled result changed");

endmodule

bind yaw_pitch_camera_basis ypcb_checker u_ypcb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .forward_x (forward_x),
  .right_y   (right_y),
  .up_y      (up_y),
  .up_z      (up_z)
);

// File: test/yaw_pitch_camera_basis_tb.sv
// yaw_pitch_camera_basis_tb: self-checking testbench for the yaw/pitch camera basis
// a directed table then random yaw/pitch deltas, checked against a local angle/trig predictor
// depends on ypcb_pkg and yaw_pitch_camera_basis
module yaw_pitch_camera_basis_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_STEPS_PER_DEGREE = ypcb_pkg::ANGLE_STEPS_PER_DEGREE;
  localparam int VECTOR_FRAC_BITS = ypcb_pkg::VECTOR_FRAC_BITS;
  localparam int QUARTER_STEPS = ypcb_pkg::QUARTER_STEPS;
  localparam int TURN_STEPS = ypcb_pkg::TURN_STEPS;
  localparam int PITCH_LIMIT = ypcb_pkg::PITCH_LIMIT;
  localparam logic [63:0] ONE_Q30 = ypcb_pkg::ONE_Q30;
  localparam logic [63:0] PI_Q30 = ypcb_pkg::PI_Q30;

  localparam int DW = ypcb_pkg::DELTA_W;
  localparam int FW = ypcb_pkg::FIELD_W;
  localparam int ROUND_SH = 30 - VECTOR_FRAC_BITS;
  localparam logic [55:0] HORNER_DIVS = {8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam int RANDOM_ITEMS = 1780;
  localparam int LONG_HOLD = 64;
  localparam int MAX_REPORTS = 40;
  localparam longint LIMIT_NS = 5_000_000;

  typedef logic [8:0][FW-1:0] basis_t;
  typedef struct {
    int     yd;
    int     pd;
    bit     typed;
    basis_t val;
  } steer_row_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // index 0 is forward_x, index 8 is up_z
  localparam logic [FW-1:0] UNIT = 16'd16384;
  localparam logic [FW-1:0] NEG_UNIT = 16'hC000;
  localparam basis_t LEVEL_BASIS = {16'd0, UNIT, 16'd0, UNIT, 16'd0, 16'd0, 16'd0, 16'd0, UNIT};
  localparam basis_t YAW90_BASIS = {16'd0, UNIT, 16'd0, 16'd0, 16'd0, NEG_UNIT, UNIT, 16'd0,
                                    16'd0};

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [DW-1:0] yaw_delta;
  logic signed [DW-1:0] pitch_delta;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [FW-1:0] forward_x, forward_y, forward_z;
  logic signed [FW-1:0] right_x, right_y, right_z;
  logic signed [FW-1:0] up_x, up_y, up_z;

  basis_t      expected_basis [$];
  int          yaw_acc = 0;
  int          pitch_acc = 0;
  int          yaw_wraps = 0;
  int          pitch_clamps = 0;
  int          mismatch_count = 0;
  int          results_checked = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          fast_items = 0;
  int          rx_tick = 0;
  bit          long_hold_req = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;

  string field_names [9] = '{"forward_x", "forward_y", "forward_z", "right_x", "right_y",
                             "right_z", "up_x", "up_y", "up_z"};

  steer_row_t steer_rows [20] = '{
    '{0, 0, 1'b1, LEVEL_BASIS},
    '{1440, 0, 1'b1, YAW90_BASIS},
    '{1440, 0, 1'b0, '0},
    '{1440, 0, 1'b0, '0},
    '{1440, 0, 1'b1, LEVEL_BASIS},
    '{8191, 0, 1'b0, '0},
    '{-8192, 0, 1'b0, '0},
    '{1, 0, 1'b1, LEVEL_BASIS},
    '{-1, 0, 1'b0, '0},
    '{0, 8191, 1'b0, '0},
    '{0, 1, 1'b0, '0},
    '{0, -8192, 1'b0, '0},
    '{0, -1, 1'b0, '0},
    '{0, 1424, 1'b0, '0},
    '{1, 0, 1'b1, LEVEL_BASIS},
    '{8191, 8191, 1'b0, '0},
    '{-8192, -8192, 1'b0, '0},
    '{720, 712, 1'b0, '0},
    '{-3000, -2000, 1'b0, '0},
    '{0, 0, 1'b0, '0}
  };

  yaw_pitch_camera_basis dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .yaw_delta(yaw_delta),
    .pitch_delta(pitch_delta),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .forward_x(forward_x),
    .forward_y(forward_y),
    .forward_z(forward_z),
    .right_x(right_x),
    .right_y(right_y),
    .right_z(right_z),
    .up_x(up_x),
    .up_y(up_y),
    .up_z(up_z)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sine of 0..90 degrees in angle steps, magnitude in vector format
  function automatic longint quarter_wave_sine(input int steps);
    logic [63:0] span;
    logic [63:0] xr;
    logic [63:0] xsq;
    logic [63:0] horner;
    logic [63:0] s;
    span = 64'(180 * ANGLE_STEPS_PER_DEGREE);
    xr = (64'(steps) * PI_Q30 + span / 64'd2) / span;
    xsq = (xr * xr) >> 30;
    horner = ONE_Q30;
    for (int k = 0; k < 7; k++) begin
      horner = ONE_Q30 - ((xsq * horner) >> 30) / 64'(HORNER_DIVS[8*(6-k) +: 8]);
    end
    s = (xr * horner) >> 30;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    s = (s + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    return longint'(s);
  endfunction

  // magnitude product rounded half away from zero, sign applied after
  function automatic longint scaled_product(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + (64'd1 << (VECTOR_FRAC_BITS - 1))) >> VECTOR_FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic basis_t advance_camera(input logic signed [DW-1:0] yd,
                                            input logic signed [DW-1:0] pd);
    int     ysum;
    int     psum;
    int     pmag;
    longint sy, cy, sp, cp;
    basis_t b;
    ysum = yaw_acc + int'(yd);
    if (ysum < 0 || ysum >= TURN_STEPS) begin
      yaw_wraps++;
    end
    ysum = ysum % TURN_STEPS;
    if (ysum < 0) begin
      ysum += TURN_STEPS;
    end
    yaw_acc = ysum;
    psum = pitch_acc + int'(pd);
    if (psum > PITCH_LIMIT || psum < -PITCH_LIMIT) begin
      pitch_clamps++;
    end
    if (psum > PITCH_LIMIT) begin
      psum = PITCH_LIMIT;
    end
    if (psum < -PITCH_LIMIT) begin
      psum = -PITCH_LIMIT;
    end
    pitch_acc = psum;

    if (ysum < QUARTER_STEPS) begin
      sy = quarter_wave_sine(ysum);
      cy = quarter_wave_sine(QUARTER_STEPS - ysum);
    end else if (ysum < 2 * QUARTER_STEPS) begin
      sy = quarter_wave_sine(2 * QUARTER_STEPS - ysum);
      cy = -quarter_wave_sine(ysum - QUARTER_STEPS);
    end else if (ysum < 3 * QUARTER_STEPS) begin
      sy = -quarter_wave_sine(ysum - 2 * QUARTER_STEPS);
      cy = -quarter_wave_sine(3 * QUARTER_STEPS - ysum);
    end else begin
      sy = -quarter_wave_sine(4 * QUARTER_STEPS - ysum);
      cy = quarter_wave_sine(ysum - 3 * QUARTER_STEPS);
    end
    pmag = (psum < 0) ? -psum : psum;
    sp = quarter_wave_sine(pmag);
    if (psum < 0) begin
      sp = -sp;
    end
    cp = quarter_wave_sine(QUARTER_STEPS - pmag);

    b[0] = 16'(scaled_product(cy, cp));
    b[1] = 16'(sp);
    b[2] = 16'(scaled_product(sy, cp));
    b[3] = 16'(-sy);
    b[4] = '0;
    b[5] = 16'(cy);
    b[6] = 16'(-scaled_product(cy, sp));
    b[7] = 16'(cp);
    b[8] = 16'(-scaled_product(sy, sp));
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic offer_item(input int yd, input int pd, input bit typed, input basis_t typed_val);
    basis_t predicted;
    int     gap;
    yaw_delta <= yd[DW-1:0];
    pitch_delta <= pd[DW-1:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = advance_camera(yd[DW-1:0], pd[DW-1:0]);
    expected_basis.push_back(typed ? typed_val : predicted);
    items_sent++;
    if (fast_items > 0) begin
      fast_items--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      yaw_delta <= DW'($urandom_range(0, 16383));
      pitch_delta <= DW'($urandom_range(0, 16383));
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 40);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_basis.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // receiver stall pattern, with an occasional long hold
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case (stall_mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((rx_tick % 7) < 3);
        endcase
        rx_tick++;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    basis_t seen;
    basis_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = {up_z, up_y, up_x, right_z, right_y, right_x, forward_z, forward_y, forward_x};
      if (expected_basis.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = expected_basis.pop_front();
        results_checked++;
        for (int f = 0; f < 9; f++) begin
          if (seen[f] !== want[f]) begin
            report_mismatch($sformatf("%s got %0d expected %0d", field_names[f],
                                      $signed(seen[f]), $signed(want[f])));
          end
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", expected_basis.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    int yd;
    int pd;
    int target;
    int drain_wait;
    rst <= 1'b1;
    in_valid <= 1'b0;
    yaw_delta <= '0;
    pitch_delta <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    stall_mode = STALL_LIGHT;
    foreach (steer_rows[i]) begin
      offer_item(steer_rows[i].yd, steer_rows[i].pd, steer_rows[i].typed, steer_rows[i].val);
    end
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      end
      if (n == 400 || n == 1000 || n == 1500) begin
        long_hold_req = 1'b1;
        fast_items = LONG_HOLD + 16;
      end
      if (n == 700 || n == 1300) begin
        wait_drained();
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          yd = int'($urandom_range(0, 128)) - 64;
          pd = int'($urandom_range(0, 128)) - 64;
        end
        5, 6: begin
          yd = int'($urandom_range(0, 16383)) - 8192;
          pd = int'($urandom_range(0, 16383)) - 8192;
        end
        7: begin
          yd = ($urandom_range(0, 1) != 0) ? 8191 : -8192;
          pd = ($urandom_range(0, 1) != 0) ? 8191 : -8192;
        end
        8: begin
          // steer onto quadrant edges and onto the pitch limits or level pitch
          target = (int'($urandom_range(0, 3)) * QUARTER_STEPS + int'($urandom_range(0, 2)) - 1
                    + TURN_STEPS) % TURN_STEPS;
          yd = target - yaw_acc;
          target = (int'($urandom_range(0, 2)) - 1) * PITCH_LIMIT + int'($urandom_range(0, 2)) - 1;
          pd = target - pitch_acc;
        end
        default: begin
          yd = int'($urandom_range(0, 4000)) - 2000;
          pd = int'($urandom_range(0, 4000)) - 2000;
        end
      endcase
      offer_item(yd, pd, 1'b0, '0);
    end

    in_valid <= 1'b0;
    stall_mode = STALL_NONE;
    drain_wait = 0;
    while (expected_basis.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    if (expected_basis.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_basis.size()));
    end

    $display("sent %0d transactions, checked %0d results", items_sent, results_checked);
    $display("yaw wrapped %0d times, pitch clamped %0d times, %0d mismatches",
             yaw_wraps, pitch_clamps, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
src/ypcb_pkg.sv
src/ypcb_ram.sv
src/yaw_pitch_camera_basis.sv
src/ypcb_checker.sv
test/yaw_pitch_camera_basis_tb.sv
